[hdl/rcc_pkg.sv]
// Shared types, constants and codes for the column ray caster.
`timescale 1ns / 1ps
package rcc_pkg;
    localparam int MAP_SIDE    = 64;
    localparam int MAP_BITS    = $clog2(MAP_SIDE);
    localparam int CX_W        = MAP_BITS + 2;
    localparam int MAX_STEPS   = 128;
    localparam int STEP_W      = $clog2(MAX_STEPS + 1);
    localparam int MAX_COLUMNS = 2048;
    localparam int COL_W       = 11;
    localparam int CELL_W      = 8;
    localparam int WALL_MAX    = 63;
    localparam int FIX_ONE     = 65536;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 22;

    // shared divider: 48-bit dividend, 42-bit divisor, one quotient bit per cycle
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 42;
    localparam int DIV_CW = $clog2(DIV_NW);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_X    = 3'd0,
        CFG_POS_Y    = 3'd1,
        CFG_DIR_X    = 3'd2,
        CFG_DIR_Y    = 3'd3,
        CFG_SCREEN_W = 3'd4,
        CFG_SCREEN_H = 3'd5,
        CFG_WALL_H   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_SHIFT,
        DIV_DT,
        DIV_RF,
        DIV_H
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SDIV,
        S_MUL,
        S_RAY,
        S_CHECK,
        S_TEST,
        S_PICK,
        S_DTDIV,
        S_RFDIV,
        S_HDIV,
        S_EMIT_HIT,
        S_EMIT_MISS
    } t_state;

    typedef struct packed {
        logic     wr;
        logic     load;
        logic     div_go;
        t_div_sel div_sel;
        logic     mul;
        logic     ray;
        logic     rd;
        logic     prod;
        logic     add_t;
        logic     move;
        logic     emit_hit;
        logic     emit_miss;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic out_map;
        logic is_wall;
        logic n_max;
        logic t_zero;
        logic blocked;
    } t_stat;
endpackage

[hdl/rcc_div.sv]
// Radix-2 restoring divider shared by every division of a cast.
`timescale 1ns / 1ps
module rcc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [rcc_pkg::DIV_NW-1:0] i_num,
    input  logic [rcc_pkg::DIV_DW-1:0] i_den,
    output logic [rcc_pkg::DIV_NW-1:0] o_q,
    output logic                       o_busy,
    output logic                       o_done
);
    import rcc_pkg::*;

    logic              r_busy, r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_q, n_q;
    logic [DIV_DW-1:0] r_rem, n_rem, r_den;
    logic [DIV_DW:0]   tr, diff;
    logic              ge;

    always_comb begin
        tr    = {r_rem, r_q[DIV_NW-1]};
        diff  = tr - {1'b0, r_den};
        ge    = tr >= {1'b0, r_den};
        n_rem = ge ? diff[DIV_DW-1:0] : tr[DIV_DW-1:0];
        n_q   = {r_q[DIV_NW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_q    = r_q;
    assign o_busy = r_busy;
    assign o_done = r_done;
endmodule

[hdl/rcc_datapath.sv]
// Datapath: configuration, tile map memory, ray setup, DDA walk and result formatting.
`timescale 1ns / 1ps
module rcc_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rcc_pkg::t_cmd                  i_cmd,
    output rcc_pkg::t_stat                 o_stat,
    input  logic                           i_cfg_we,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [10:0]                    i_column,
    input  logic [11:0]                    i_cell_index,
    input  logic [7:0]                     i_cell_value,
    output logic                           o_valid,
    output logic [10:0]                    o_column_out,
    output logic                           o_status,
    output logic [5:0]                     o_hit_cell_x,
    output logic [5:0]                     o_hit_cell_y,
    output logic                           o_wall_side,
    output logic signed [7:0]              o_texture_index,
    output logic [5:0]                     o_texture_column,
    output logic signed [19:0]             o_texel_offset,
    output logic [23:0]                    o_distance,
    output logic [15:0]                    o_line_height,
    output logic signed [16:0]             o_wall_top
);
    import rcc_pkg::*;

    // configuration
    logic [21:0]        r_pos_x, r_pos_y;
    logic signed [17:0] r_dir_x, r_dir_y;
    logic [11:0]        r_sw, r_sh;
    logic [15:0]        r_wh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= 22'd2097152;
            r_pos_y <= 22'd2097152;
            r_dir_x <= 18'sd65536;
            r_dir_y <= 18'sd0;
            r_sw    <= 12'd640;
            r_sh    <= 12'd400;
            r_wh    <= 16'd320;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_POS_X:    r_pos_x <= i_cfg_data;
                CFG_POS_Y:    r_pos_y <= i_cfg_data;
                CFG_DIR_X:    r_dir_x <= i_cfg_data[17:0];
                CFG_DIR_Y:    r_dir_y <= i_cfg_data[17:0];
                CFG_SCREEN_W: r_sw    <= i_cfg_data[11:0];
                CFG_SCREEN_H: r_sh    <= i_cfg_data[11:0];
                CFG_WALL_H:   r_wh    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // tile map
    logic [CELL_W-1:0] mem [MAP_SIDE*MAP_SIDE];
    logic [CELL_W-1:0] r_cell;
    logic [CX_W-1:0]   r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && (13'(i_cell_index) < 13'(MAP_SIDE * MAP_SIDE)))
            mem[i_cell_index[2*MAP_BITS-1:0]] <= i_cell_value;
        if (i_cmd.rd)
            r_cell <= mem[{r_cy[MAP_BITS-1:0], r_cx[MAP_BITS-1:0]}];
    end

    // walk state
    logic [COL_W-1:0]   r_col;
    logic               r_shift_neg;
    logic signed [46:0] r_pmx, r_pmy;
    logic [30:0]        r_arx, r_ary;
    logic               r_sx_neg, r_sy_neg;
    logic [16:0]        r_rfx, r_rfy;
    logic [40:0]        r_t;
    logic [STEP_W-1:0]  r_n;
    logic [47:0]        r_pa, r_pb;

    logic [DIV_NW-1:0]  div_num, div_q;
    logic [DIV_DW-1:0]  div_den;
    logic               div_busy, div_done;

    logic [11:0]        w_eff, d_mag;
    logic [12:0]        d;
    logic               horiz;
    logic signed [28:0] shift_s;
    logic [31:0]        rdx, rdy;
    logic [15:0]        fx, fy;

    always_comb begin
        w_eff = (r_sw == 12'd0) ? 12'd1 : r_sw;
        d     = {1'b0, i_column, 1'b0} - {1'b0, w_eff};
        d_mag = d[12] ? 12'(-d) : d[11:0];
        horiz = r_pa <= r_pb;
        unique case (i_cmd.div_sel)
            DIV_SHIFT: begin
                div_num = {20'd0, d_mag, 16'd0};
                div_den = {30'd0, w_eff};
            end
            DIV_DT: begin
                div_num = horiz ? {15'd0, r_rfx, 16'd0} : {15'd0, r_rfy, 16'd0};
                div_den = horiz ? {11'd0, r_arx} : {11'd0, r_ary};
            end
            DIV_RF: begin
                div_num = horiz ? r_pa : r_pb;
                div_den = horiz ? {11'd0, r_arx} : {11'd0, r_ary};
            end
            DIV_H: begin
                div_num = {16'd0, r_wh, 16'd0};
                div_den = {r_t, 1'b0};
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
        shift_s = r_shift_neg ? -$signed({1'b0, div_q[27:0]}) : $signed({1'b0, div_q[27:0]});
        rdx = {{14{r_dir_x[17]}}, r_dir_x} - {r_pmx[46], r_pmx[46:16]};
        rdy = {{14{r_dir_y[17]}}, r_dir_y} + {r_pmy[46], r_pmy[46:16]};
        fx  = r_pos_x[15:0];
        fy  = r_pos_y[15:0];
    end

    rcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_q     (div_q),
        .o_busy  (div_busy),
        .o_done  (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col       <= i_column;
            r_shift_neg <= d[12];
        end
        if (i_cmd.mul) begin
            r_pmx <= shift_s * r_dir_y;
            r_pmy <= shift_s * r_dir_x;
        end
        if (i_cmd.ray) begin
            r_sx_neg <= rdx[31];
            r_sy_neg <= rdy[31];
            r_arx    <= rdx[31] ? 31'(-rdx) : rdx[30:0];
            r_ary    <= rdy[31] ? 31'(-rdy) : rdy[30:0];
            // a position right on a boundary, facing negative, starts in the next cell
            r_rfx <= rdx[31] ? ((fx == 16'd0) ? 17'(FIX_ONE) : {1'b0, fx})
                             : 17'(FIX_ONE) - {1'b0, fx};
            r_rfy <= rdy[31] ? ((fy == 16'd0) ? 17'(FIX_ONE) : {1'b0, fy})
                             : 17'(FIX_ONE) - {1'b0, fy};
            r_cx  <= CX_W'(r_pos_x[21:16]) - CX_W'(rdx[31] && fx == 16'd0);
            r_cy  <= CX_W'(r_pos_y[21:16]) - CX_W'(rdy[31] && fy == 16'd0);
            r_t   <= '0;
            r_n   <= '0;
        end
        if (i_cmd.prod) begin
            r_pa <= r_rfx * r_ary;
            r_pb <= r_rfy * r_arx;
        end
        if (i_cmd.add_t)
            r_t <= r_t + div_q[40:0];
        if (i_cmd.move) begin
            r_n <= r_n + 1'b1;
            if (horiz) begin
                r_rfy <= r_rfy - div_q[16:0];
                r_rfx <= 17'(FIX_ONE);
                r_cx  <= r_sx_neg ? r_cx - 1'b1 : r_cx + 1'b1;
            end else begin
                r_rfx <= r_rfx - div_q[16:0];
                r_rfy <= 17'(FIX_ONE);
                r_cy  <= r_sy_neg ? r_cy - 1'b1 : r_cy + 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.div_busy = div_busy;
        o_stat.div_done = div_done;
        o_stat.out_map  = (r_cx >= CX_W'(MAP_SIDE)) || (r_cy >= CX_W'(MAP_SIDE));
        o_stat.is_wall  = r_cell <= CELL_W'(WALL_MAX);
        o_stat.n_max    = r_n >= STEP_W'(MAX_STEPS);
        o_stat.t_zero   = r_t == '0;
        o_stat.blocked  = horiz && (r_arx == '0);
    end

    // result formatting
    logic              side, same;
    logic [9:0]        tidx;
    logic [16:0]       tx;
    logic [6:0]        tcol_raw;
    logic [5:0]        tcol;
    logic [22:0]       toff;
    logic [15:0]       h;
    logic [16:0]       top;

    always_comb begin
        side     = r_rfx == 17'(FIX_ONE);
        same     = r_sx_neg == r_sy_neg;
        if (side) begin
            tidx = {1'b0, r_cell, 1'b0} - 10'd1;
            tx   = same ? 17'(FIX_ONE) - r_rfy : r_rfy;
        end else begin
            tidx = {1'b0, r_cell, 1'b0} - 10'd2;
            tx   = !same ? 17'(FIX_ONE) - r_rfx : r_rfx;
        end
        tcol_raw = tx[16:10];
        tcol     = tcol_raw[6] ? 6'd63 : tcol_raw[5:0];
        toff     = 23'd4096 + {tidx[9], tidx, 12'd0} + {11'd0, tcol, 6'd0};
        if (r_t == '0 || div_q[DIV_NW-1:16] != '0)
            h = 16'hFFFF;
        else
            h = div_q[15:0];
        top = {6'd0, r_sh[11:1]} - {1'b0, h};
    end

    logic r_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_valid <= 1'b0;
        else
            r_valid <= i_cmd.emit_hit || i_cmd.emit_miss;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_hit || i_cmd.emit_miss) begin
            o_column_out     <= r_col;
            o_status         <= i_cmd.emit_miss;
            o_hit_cell_x     <= i_cmd.emit_hit ? r_cx[5:0] : '0;
            o_hit_cell_y     <= i_cmd.emit_hit ? r_cy[5:0] : '0;
            o_wall_side      <= i_cmd.emit_hit && side;
            o_texture_index  <= i_cmd.emit_hit ? tidx[7:0] : '0;
            o_texture_column <= i_cmd.emit_hit ? tcol : '0;
            o_texel_offset   <= i_cmd.emit_hit ? toff[19:0] : '0;
            o_distance       <= !i_cmd.emit_hit ? '0 :
                                (r_t[40:24] != '0) ? 24'hFFFFFF : r_t[23:0];
            o_line_height    <= i_cmd.emit_hit ? h : '0;
            o_wall_top       <= i_cmd.emit_hit ? top : '0;
        end
    end

    assign o_valid = r_valid;
endmodule

[hdl/rcc_ctrl.sv]
// Controller: sequences map writes, ray setup, the cell walk and result emission.
`timescale 1ns / 1ps
module rcc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_action,
    input  rcc_pkg::t_stat i_stat,
    output rcc_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import rcc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (!i_action) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.load    = 1'b1;
                        o_cmd.div_go  = 1'b1;
                        o_cmd.div_sel = DIV_SHIFT;
                        n_state       = S_SDIV;
                    end
                end
            end
            S_SDIV: if (i_stat.div_done) n_state = S_MUL;
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RAY;
            end
            S_RAY: begin
                o_cmd.ray = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.out_map) begin
                    n_state = S_EMIT_MISS;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_TEST;
                end
            end
            S_TEST: begin
                if (i_stat.is_wall) begin
                    if (i_stat.t_zero) begin
                        n_state = S_EMIT_HIT;
                    end else begin
                        o_cmd.div_go  = 1'b1;
                        o_cmd.div_sel = DIV_H;
                        n_state       = S_HDIV;
                    end
                end else if (i_stat.n_max) begin
                    n_state = S_EMIT_MISS;
                end else begin
                    o_cmd.prod = 1'b1;
                    n_state    = S_PICK;
                end
            end
            S_PICK: begin
                if (i_stat.blocked) begin
                    n_state = S_EMIT_MISS;
                end else begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = DIV_DT;
                    n_state       = S_DTDIV;
                end
            end
            S_DTDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.add_t   = 1'b1;
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = DIV_RF;
                    n_state       = S_RFDIV;
                end
            end
            S_RFDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.move = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_HDIV: if (i_stat.div_done) n_state = S_EMIT_HIT;
            S_EMIT_HIT: begin
                o_cmd.emit_hit = 1'b1;
                n_state        = S_IDLE;
            end
            S_EMIT_MISS: begin
                o_cmd.emit_miss = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = r_state != S_IDLE;

    a_rd_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |-> !i_stat.out_map)
        else $error("map read outside the map");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_go |-> !i_stat.div_busy)
        else $error("divider started while busy");

    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_SDIV || r_state == S_DTDIV ||
                             r_state == S_RFDIV || r_state == S_HDIV))
        else $error("divider finished with nobody waiting");
endmodule

[hdl/grid_ray_caster_column_core.sv]
// Top level of the column ray caster: controller plus datapath.
`timescale 1ns / 1ps
// Usage:
//  - Command channel: drive i_action and its fields with start high; the beat is
//    taken at a rising edge where busy is low. i_action 0 writes one map byte
//    (no result); i_action 1 casts one ray for i_column.
//  - Every map cell that a ray can reach must be written before a cast.
//  - Result: one beat per cast on the o_* ports, marked by o_valid for one cycle.
//    The receiver cannot stall; results are never held.
//  - Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write a register; the user must
//    write only while busy is low, which the block itself does not enforce.
//  - Sequencing: every division runs on one shared bit-serial divider. Ray setup
//    is one division; each cell crossed adds two divisions plus the check, test
//    and pick states. A hit at zero distance is emitted without a division; any
//    other hit first divides for the line height. Up to 128 cells may be crossed.
//    busy drops as the result appears.
//  - Reset (synchronous, active low) returns the controller to idle and loads
//    the default pose and screen setup; map contents are not cleared.
module grid_ray_caster_column_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_action,
    input  logic [10:0]                    i_column,
    input  logic [11:0]                    i_cell_index,
    input  logic [7:0]                     i_cell_value,
    input  logic                           i_cfg_we,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_valid,
    output logic [10:0]                    o_column_out,
    output logic                           o_status,
    output logic [5:0]                     o_hit_cell_x,
    output logic [5:0]                     o_hit_cell_y,
    output logic                           o_wall_side,
    output logic signed [7:0]              o_texture_index,
    output logic [5:0]                     o_texture_column,
    output logic signed [19:0]             o_texel_offset,
    output logic [23:0]                    o_distance,
    output logic [15:0]                    o_line_height,
    output logic signed [16:0]             o_wall_top
);
    import rcc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    rcc_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_column         (i_column),
        .i_cell_index     (i_cell_index),
        .i_cell_value     (i_cell_value),
        .o_valid          (o_valid),
        .o_column_out     (o_column_out),
        .o_status         (o_status),
        .o_hit_cell_x     (o_hit_cell_x),
        .o_hit_cell_y     (o_hit_cell_y),
        .o_wall_side      (o_wall_side),
        .o_texture_index  (o_texture_index),
        .o_texture_column (o_texture_column),
        .o_texel_offset   (o_texel_offset),
        .o_distance       (o_distance),
        .o_line_height    (o_line_height),
        .o_wall_top       (o_wall_top)
    );
endmodule
